// ===== sv/vnd_pkg.sv =====
// shared types, constants and arithmetic helpers for the value noise vertex displacement block
// no dependencies
package vnd_pkg;

	localparam int unsigned LOW_OCTAVES_DEF = 3;
	localparam int unsigned NOISE_LAT = 6;

	typedef logic signed [31:0] crd_t;
	typedef crd_t [2:0] vec_t;
	typedef logic signed [15:0] pos_t;
	typedef pos_t [2:0] pvec_t;

	// lattice hash primes and pcg constants
	localparam logic [31:0] HASH_K [3] = '{32'h27d4eb2d, 32'h165667b1, 32'hd1b54a35};
	localparam logic [31:0] PCG_MUL = 32'd747796405;
	localparam logic [31:0] PCG_INC = 32'd2891336453;
	localparam logic [31:0] PCG_OUT = 32'd277803737;
	localparam logic [31:0] SEED_MID = 32'd17;
	localparam logic [31:0] SEED_FINE = 32'd101;

	// frequency factors, q.16
	localparam logic signed [19:0] FREQ_LOW = 20'sd91750;
	localparam logic signed [19:0] FREQ_MID = 20'sd209715;
	localparam logic signed [19:0] FREQ_FINE = 20'sd491520;
	localparam logic signed [19:0] FREQ_STEP = 20'sd139592;

	// mixing gains q0.16, offsets q0.24
	localparam logic signed [17:0] GAIN_LOW = 18'sd36045;
	localparam logic signed [17:0] GAIN_RIDGE = 18'sd11796;
	localparam logic signed [17:0] GAIN_FINE = 18'sd3277;
	localparam logic signed [25:0] OFS_LOW = 26'sd9227469;
	localparam logic signed [25:0] OFS_RIDGE = 26'sd7549747;
	localparam logic signed [25:0] OFS_FINE = 26'sd8388608;
	localparam logic signed [26:0] ONE_Q24 = 27'sd16777216;
	localparam logic signed [26:0] D_FLOOR = -27'sd5872026;

	// coordinate times q.16 factor, floored
	function automatic crd_t scale(input crd_t c, input logic signed [19:0] k);
		logic signed [51:0] p;
		p = c * k;
		return p[47:16];
	endfunction

	// lattice cell (plus optional one) times hash prime, modulo 2^32
	function automatic logic [31:0] corner_mul(input crd_t c, input logic [31:0] k,
			input logic inc);
		logic [31:0] u;
		u = 32'(c >>> 14) + {31'b0, inc};
		return u * k;
	endfunction

	// f*f >> 16 with f the cell fraction as q0.16
	function automatic logic [15:0] ease_sq(input logic [13:0] fr);
		logic [15:0] f;
		logic [31:0] sq;
		f = {fr, 2'b00};
		sq = f * f;
		return sq[31:16];
	endfunction

	// smoothstep weight from the squared fraction
	function automatic logic [15:0] ease_fin(input logic [13:0] fr, input logic [15:0] f2);
		logic [17:0] sm;
		logic [33:0] pr;
		sm = 18'd196608 - {1'b0, fr, 3'b000};
		pr = f2 * sm;
		return pr[31:16];
	endfunction

	function automatic logic [31:0] pcg_step(input logic [31:0] h);
		return h * PCG_MUL + PCG_INC;
	endfunction

	function automatic logic [31:0] pcg_mix(input logic [31:0] st);
		logic [4:0] sh;
		sh = {1'b0, st[31:28]} + 5'd4;
		return ((st >> sh) ^ st) * PCG_OUT;
	endfunction

	function automatic logic [23:0] pcg_fold(input logic [31:0] mx);
		logic [31:0] t;
		t = (mx >> 22) ^ mx;
		return t[23:0];
	endfunction

	// (a*(1-s) + b*s) >> 16
	function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
			input logic [15:0] s);
		logic [16:0] sc;
		logic [41:0] t;
		sc = 17'd65536 - {1'b0, s};
		t = a * sc + b * s;
		return t[39:16];
	endfunction

	// q.24 product back to q2.14 with saturation
	function automatic pos_t sat16(input logic signed [42:0] v);
		logic signed [18:0] t;
		t = v[42:24];
		if (t > 19'sd32767) begin
			return 16'sh7fff;
		end else if (t < -19'sd32768) begin
			return 16'sh8000;
		end
		return t[15:0];
	endfunction

endpackage

// ===== sv/vnd_noise.sv =====
// six stage 3d value noise unit: lattice hash, pcg, trilinear smoothstep blend
// depends on vnd_pkg
module vnd_noise import vnd_pkg::*; (
	input  logic        clk,
	input  logic        adv,
	input  logic [31:0] seed,
	input  vec_t        crd,
	output logic [23:0] noise
);

	logic [31:0] hk_s1 [3][2];
	logic [13:0] fr_s1 [3];
	logic [15:0] f2_s1 [3];
	logic [31:0] st_s2 [8];
	logic [15:0] w_s2 [3];
	logic [31:0] mx_s3 [8];
	logic [15:0] w_s3 [3];
	logic [23:0] e_s4 [4];
	logic [15:0] w_s4 [2];
	logic [23:0] g_s5 [2];
	logic [15:0] w_s5;
	logic [23:0] n_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				hk_s1[a][0] <= corner_mul(crd[a], HASH_K[a], 1'b0);
				hk_s1[a][1] <= corner_mul(crd[a], HASH_K[a], 1'b1);
				fr_s1[a] <= crd[a][13:0];
				f2_s1[a] <= ease_sq(crd[a][13:0]);
			end
			// corner n: bit 0 x, bit 1 y, bit 2 z
			for (int n = 0; n < 8; n++) begin
				st_s2[n] <= pcg_step(hk_s1[0][n[0]] ^ hk_s1[1][n[1]] ^ hk_s1[2][n[2]] ^ seed);
			end
			for (int a = 0; a < 3; a++) begin
				w_s2[a] <= ease_fin(fr_s1[a], f2_s1[a]);
			end
			for (int n = 0; n < 8; n++) begin
				mx_s3[n] <= pcg_mix(st_s2[n]);
			end
			w_s3 <= w_s2;
			for (int j = 0; j < 4; j++) begin
				e_s4[j] <= blend(pcg_fold(mx_s3[2*j]), pcg_fold(mx_s3[2*j+1]), w_s3[0]);
			end
			w_s4[0] <= w_s3[1];
			w_s4[1] <= w_s3[2];
			g_s5[0] <= blend(e_s4[0], e_s4[1], w_s4[0]);
			g_s5[1] <= blend(e_s4[2], e_s4[3], w_s4[0]);
			w_s5 <= w_s4[1];
			n_s6 <= blend(g_s5[0], g_s5[1], w_s5);
		end
	end

	assign noise = n_s6;

endmodule

// ===== sv/value_noise_vertex_displace_top.sv =====
// value noise vertex displacement: input beats pass the coordinate stages, the noise units and the mix
// stages to the output register, one beat per cycle sustained; the whole pipeline stalls together
// only while the output register holds a beat that is not taken
// arst_n clears all valid bits and the seed register; data registers are not reset
// depends on vnd_pkg and vnd_noise
module value_noise_vertex_displace_top import vnd_pkg::*; #(
	parameter int unsigned LOW_OCTAVES = LOW_OCTAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// vertex input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	// displaced vertex output
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z
);

	localparam int unsigned NO = LOW_OCTAVES;
	localparam int unsigned NU = LOW_OCTAVES + 2;
	localparam logic REG_SEED = 1'b0;

	// global advance: every stage moves when the output register is free or drained
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// seed register
	logic [31:0] seed_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_SEED) begin
			seed_q <= pwdata;
		end
	end
	assign prdata = (paddr[2] == REG_SEED) ? seed_q : '0;

	pvec_t pin;
	assign pin = {pos_z, pos_y, pos_x};

	// coordinate stages: stage 0 scales to the low, mid and fine frequencies,
	// stage j derives octave j from octave j-1
	vec_t  oct_sc [NO][NO];
	vec_t  mid_sc [NO];
	vec_t  fine_sc [NO];
	pvec_t pos_sc [NO];
	logic  vld_sc [NO];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NO; o++) begin
				for (int a = 0; a < 3; a++) begin
					oct_sc[0][o][a] <= scale(crd_t'(pin[a]), FREQ_LOW);
				end
			end
			for (int a = 0; a < 3; a++) begin
				mid_sc[0][a] <= scale(crd_t'(pin[a]), FREQ_MID);
				fine_sc[0][a] <= scale(crd_t'(pin[a]), FREQ_FINE);
			end
			pos_sc[0] <= pin;
			for (int j = 1; j < NO; j++) begin
				for (int o = 0; o < NO; o++) begin
					for (int a = 0; a < 3; a++) begin
						if (o == j) begin
							oct_sc[j][o][a] <= scale(oct_sc[j-1][j-1][a], FREQ_STEP);
						end else begin
							oct_sc[j][o][a] <= oct_sc[j-1][o][a];
						end
					end
				end
				mid_sc[j] <= mid_sc[j-1];
				fine_sc[j] <= fine_sc[j-1];
				pos_sc[j] <= pos_sc[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NO; j++) begin
				vld_sc[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_sc[0] <= in_valid;
			for (int j = 1; j < NO; j++) begin
				vld_sc[j] <= vld_sc[j-1];
			end
		end
	end

	// noise units: octaves first, then the ridged mid layer, then the fine layer
	logic [23:0] nz [NU];
	for (genvar u = 0; u < NU; u++) begin : g_nz
		vec_t        crd_u;
		logic [31:0] seed_u;
		if (u < NO) begin : g_low
			assign crd_u = oct_sc[NO-1][u];
			assign seed_u = seed_q;
		end else if (u == NO) begin : g_mid
			assign crd_u = mid_sc[NO-1];
			assign seed_u = seed_q + SEED_MID;
		end else begin : g_fine
			assign crd_u = fine_sc[NO-1];
			assign seed_u = seed_q + SEED_FINE;
		end
		vnd_noise u_noise (
			.clk   (clk),
			.adv   (adv),
			.seed  (seed_u),
			.crd   (crd_u),
			.noise (nz[u])
		);
	end

	// valid and position ride alongside the noise units
	pvec_t pos_sn [NOISE_LAT];
	logic  vld_sn [NOISE_LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_sn[0] <= pos_sc[NO-1];
			for (int k = 1; k < NOISE_LAT; k++) begin
				pos_sn[k] <= pos_sn[k-1];
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NOISE_LAT; k++) begin
				vld_sn[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_sn[0] <= vld_sc[NO-1];
			for (int k = 1; k < NOISE_LAT; k++) begin
				vld_sn[k] <= vld_sn[k-1];
			end
		end
	end

	// mix stages, numbered from the noise output
	logic [24:0] acc_c;
	logic signed [25:0] dev_c;
	logic signed [25:0] ridge_c;
	always_comb begin
		acc_c = '0;
		for (int i = 0; i < NO; i++) begin
			acc_c = acc_c + 25'(nz[i] >> (i + 1));
		end
		// ridge = 1 - |2n - 1|
		dev_c = $signed({1'b0, nz[NO], 1'b0}) - 26'sd16777216;
		if (dev_c < 0) begin
			dev_c = -dev_c;
		end
		ridge_c = 26'sd16777216 - dev_c;
	end

	logic [24:0]        acc_s1;
	logic signed [25:0] ridge_s1;
	logic [23:0]        fine_s1;
	pvec_t              pos_s1;
	logic signed [43:0] plow_s2, pridge_s2, pfine_s2;
	pvec_t              pos_s2;
	logic signed [26:0] scl_s3;
	pvec_t              pos_s3;
	logic               vld_s1, vld_s2, vld_s3;

	logic signed [45:0] dsum_c;
	logic signed [29:0] d_c;
	assign dsum_c = 46'(plow_s2) + 46'(pridge_s2) + 46'(pfine_s2);
	always_comb begin
		d_c = dsum_c[45:16];
		if (d_c < 30'(D_FLOOR)) begin
			d_c = 30'(D_FLOOR);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s1 <= acc_c;
			ridge_s1 <= ridge_c;
			fine_s1 <= nz[NO+1];
			pos_s1 <= pos_sn[NOISE_LAT-1];
			// products land in q.40
			plow_s2 <= ($signed({1'b0, acc_s1}) - OFS_LOW) * GAIN_LOW;
			pridge_s2 <= (ridge_s1 - OFS_RIDGE) * GAIN_RIDGE;
			pfine_s2 <= ($signed({2'b0, fine_s1}) - OFS_FINE) * GAIN_FINE;
			pos_s2 <= pos_s1;
			// radial scale 1 + d in q.24
			scl_s3 <= ONE_Q24 + 27'(d_c);
			pos_s3 <= pos_s2;
			out_x <= sat16(pos_s3[0] * scl_s3);
			out_y <= sat16(pos_s3[1] * scl_s3);
			out_z <= sat16(pos_s3[2] * scl_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_sn[NOISE_LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	// checks
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_sc[0])
		else $error("accepted input beat missing from first stage");

	a_ridge_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ridge_s1 >= 0 && ridge_s1 <= 26'sd16777216)
		else $error("ridge term out of range");

	a_scale_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> scl_s3 >= ONE_Q24 + D_FLOOR)
		else $error("displacement below clamp");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_s3) && $stable(scl_s3))
		else $error("pipeline moved during stall");

endmodule
